@@ src/hsv2rgb_pkg.sv @@
// Shared types and constants for the HSV to RGB converter pipeline.
// Used by every module under src; has no dependencies of its own.
`default_nettype none

package hsv2rgb_pkg;

    // Field widths
    localparam int HUE_W    = 15;
    localparam int UNIT_W   = 9;
    localparam int CHAN_W   = 8;
    localparam int SECTOR_W = 4;
    localparam int REM_W    = 12;
    localparam int INNER_W  = 20;
    localparam int LEVEL_W  = 28;

    // Fixed-point constants: one sector is 60 degrees at 64 units per degree
    localparam logic [HUE_W-1:0]   SECTOR_UNITS = 15'd3840;
    localparam logic [HUE_W-1:0]   FULL_CIRCLE  = 15'd23040;
    localparam logic [UNIT_W-1:0]  UNIT_ONE     = 9'd256;
    localparam logic [INNER_W-1:0] INNER_ONE    = 20'd983040;
    localparam int                 NUM_BOUNDS   = 8;

    // Sector codes (anything above the last named one uses the magenta row)
    localparam logic [SECTOR_W-1:0] SEC_RED_YEL = 4'd0;
    localparam logic [SECTOR_W-1:0] SEC_YEL_GRN = 4'd1;
    localparam logic [SECTOR_W-1:0] SEC_GRN_CYN = 4'd2;
    localparam logic [SECTOR_W-1:0] SEC_CYN_BLU = 4'd3;
    localparam logic [SECTOR_W-1:0] SEC_BLU_MAG = 4'd4;

    // Beat between the sector splitter and the level multipliers
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [REM_W-1:0]    rem;
        logic [UNIT_W-1:0]   sat;
        logic [UNIT_W-1:0]   bri;
    } t_sector_beat;

    // Beat between the level multipliers and the channel mixer
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [LEVEL_W-1:0]  lvl_v;
        logic [LEVEL_W-1:0]  lvl_p;
        logic [LEVEL_W-1:0]  lvl_q;
        logic [LEVEL_W-1:0]  lvl_t;
    } t_level_beat;

    // Hue at the start of a sector (constant multiply, shifts and adds)
    function automatic logic [HUE_W-1:0] sector_base(input logic [SECTOR_W-1:0] sec);
        logic [HUE_W-1:0] base;
        base = HUE_W'(sec) * SECTOR_UNITS;
        return base;
    endfunction

endpackage

`default_nettype wire

@@ src/hsv2rgb_sector.sv @@
// Two-stage front end: clamps the inputs, finds the 60-degree sector and
// the remainder within it. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_sector
    import hsv2rgb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output      logic               o_ready,
    input  wire logic [HUE_W-1:0]   i_hue,
    input  wire logic [UNIT_W-1:0]  i_sat,
    input  wire logic [UNIT_W-1:0]  i_bri,
    output      logic               o_valid,
    input  wire logic               i_ready,
    output      t_sector_beat       o_beat
);

    logic                r_v1, r_v2;
    logic                w_rdy1, w_rdy2;
    logic [HUE_W-1:0]    r_h1;
    logic [SECTOR_W-1:0] r_sec1;
    logic [UNIT_W-1:0]   r_s1, r_b1;
    t_sector_beat        r_beat2;

    logic [HUE_W-1:0]    n_h1;
    logic [SECTOR_W-1:0] n_sec1;
    logic [UNIT_W-1:0]   n_s1, n_b1;
    logic [REM_W-1:0]    n_rem2;

    // Each stage moves when it is empty or the next one moves
    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Stage 1: clamp, fold full circle to zero, count sector bounds passed
    always_comb begin
        n_s1 = (i_sat > UNIT_ONE) ? UNIT_ONE : i_sat;
        n_b1 = (i_bri > UNIT_ONE) ? UNIT_ONE : i_bri;
        n_h1 = (i_hue == FULL_CIRCLE) ? '0 : i_hue;
        n_sec1 = '0;
        for (int k = 1; k <= NUM_BOUNDS; k++) begin
            n_sec1 = n_sec1 + SECTOR_W'(n_h1 >= HUE_W'(k * SECTOR_UNITS));
        end
    end

    // Stage 2: remainder within the sector
    assign n_rem2 = REM_W'(r_h1 - sector_base(r_sec1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_h1   <= n_h1;
            r_sec1 <= n_sec1;
            r_s1   <= n_s1;
            r_b1   <= n_b1;
        end
        if (w_rdy2 && r_v1) begin
            r_beat2.sector <= r_sec1;
            r_beat2.rem    <= n_rem2;
            r_beat2.sat    <= r_s1;
            r_beat2.bri    <= r_b1;
        end
    end

    assign o_valid = r_v2;
    assign o_beat  = r_beat2;

    // The remainder always lies inside one sector
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_beat2.rem < REM_W'(SECTOR_UNITS)))
        else $error("sector remainder out of range");

    // A 15-bit hue passes at most eight sector bounds
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_sec1 <= SECTOR_W'(NUM_BOUNDS)))
        else $error("sector code out of range");

endmodule

`default_nettype wire

@@ src/hsv2rgb_level.sv @@
// Two multiply stages: builds the p, q and t inner terms from saturation,
// then scales all four by brightness. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_level
    import hsv2rgb_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output      logic         o_ready,
    input  wire t_sector_beat i_beat,
    output      logic         o_valid,
    input  wire logic         i_ready,
    output      t_level_beat  o_beat
);

    localparam int PROD_W = INNER_W + 1;
    localparam int WIDE_W = INNER_W + UNIT_W;

    logic                r_v3, r_v4;
    logic                w_rdy3, w_rdy4;
    logic [SECTOR_W-1:0] r_sec3;
    logic [UNIT_W-1:0]   r_b3;
    logic [INNER_W-1:0]  r_in_p3, r_in_q3, r_in_t3;
    t_level_beat         r_beat4;

    logic [REM_W-1:0]    w_xt;
    logic [PROD_W-1:0]   w_prod_p, w_prod_q, w_prod_t;
    logic [WIDE_W-1:0]   w_lv, w_lp, w_lq, w_lt;

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign o_ready = w_rdy3;

    // Stage 3: saturation times sector fraction, subtracted from one
    assign w_xt     = REM_W'(SECTOR_UNITS) - i_beat.rem;
    assign w_prod_p = PROD_W'(i_beat.sat) * PROD_W'(SECTOR_UNITS);
    assign w_prod_q = PROD_W'(i_beat.sat) * PROD_W'(i_beat.rem);
    assign w_prod_t = PROD_W'(i_beat.sat) * PROD_W'(w_xt);

    // Stage 4: brightness times each inner term
    assign w_lv = WIDE_W'(r_b3) * WIDE_W'(INNER_ONE);
    assign w_lp = WIDE_W'(r_b3) * WIDE_W'(r_in_p3);
    assign w_lq = WIDE_W'(r_b3) * WIDE_W'(r_in_q3);
    assign w_lt = WIDE_W'(r_b3) * WIDE_W'(r_in_t3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy3) r_v3 <= i_valid;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_valid) begin
            r_sec3  <= i_beat.sector;
            r_b3    <= i_beat.bri;
            r_in_p3 <= INNER_W'(PROD_W'(INNER_ONE) - w_prod_p);
            r_in_q3 <= INNER_W'(PROD_W'(INNER_ONE) - w_prod_q);
            r_in_t3 <= INNER_W'(PROD_W'(INNER_ONE) - w_prod_t);
        end
        if (w_rdy4 && r_v3) begin
            r_beat4.sector <= r_sec3;
            r_beat4.lvl_v  <= LEVEL_W'(w_lv);
            r_beat4.lvl_p  <= LEVEL_W'(w_lp);
            r_beat4.lvl_q  <= LEVEL_W'(w_lq);
            r_beat4.lvl_t  <= LEVEL_W'(w_lt);
        end
    end

    assign o_valid = r_v4;
    assign o_beat  = r_beat4;

    // No channel level may exceed full brightness
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_beat4.lvl_p <= r_beat4.lvl_v && r_beat4.lvl_q <= r_beat4.lvl_v
                  && r_beat4.lvl_t <= r_beat4.lvl_v))
        else $error("channel level above value level");

endmodule

`default_nettype wire

@@ src/hsv2rgb_mix.sv @@
// Output stage: scales each level to 0..255 and routes value, p, q and t
// to red, green and blue by sector. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_mix
    import hsv2rgb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire t_level_beat       i_beat,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      logic [CHAN_W-1:0] o_red,
    output      logic [CHAN_W-1:0] o_green,
    output      logic [CHAN_W-1:0] o_blue
);

    localparam int SCALE_W = 32;

    logic               r_v5;
    logic               w_rdy5;
    logic [CHAN_W-1:0]  r_red, r_green, r_blue;
    logic [CHAN_W-1:0]  w_cv, w_cp, w_cq, w_ct;
    logic [CHAN_W-1:0]  n_red, n_green, n_blue;

    // 255 / (256*256*3840) = 17 / 2^24: times 17, keep the top byte
    function automatic logic [CHAN_W-1:0] to_chan(input logic [LEVEL_W-1:0] lvl);
        logic [SCALE_W-1:0] x17;
        x17 = SCALE_W'({lvl, 4'b0000}) + SCALE_W'(lvl);
        return x17[SCALE_W-1 -: CHAN_W];
    endfunction

    assign w_rdy5  = !r_v5 || i_ready;
    assign o_ready = w_rdy5;

    assign w_cv = to_chan(i_beat.lvl_v);
    assign w_cp = to_chan(i_beat.lvl_p);
    assign w_cq = to_chan(i_beat.lvl_q);
    assign w_ct = to_chan(i_beat.lvl_t);

    // Six-case sector table; out-of-range hue falls into the magenta row
    always_comb begin
        case (i_beat.sector)
            SEC_RED_YEL: begin n_red = w_cv; n_green = w_ct; n_blue = w_cp; end
            SEC_YEL_GRN: begin n_red = w_cq; n_green = w_cv; n_blue = w_cp; end
            SEC_GRN_CYN: begin n_red = w_cp; n_green = w_cv; n_blue = w_ct; end
            SEC_CYN_BLU: begin n_red = w_cp; n_green = w_cq; n_blue = w_cv; end
            SEC_BLU_MAG: begin n_red = w_ct; n_green = w_cp; n_blue = w_cv; end
            default:     begin n_red = w_cv; n_green = w_cp; n_blue = w_cq; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_rdy5) begin
            r_v5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && i_valid) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_v5;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

@@ src/hsv_to_rgb_converter_core.sv @@
// HSV to RGB converter, top level: streams HSV beats in and RGB beats out.
// Instantiates hsv2rgb_sector, hsv2rgb_level and hsv2rgb_mix; uses hsv2rgb_pkg.
//
// Input channel (s_*): one HSV color per beat. Hue is degrees times 64
// (0..23040, 23040 folds to 0), saturation and brightness in 1/256 units;
// values above 256 clamp to 256. Output channel (m_*): one 8-bit RGB
// color per beat, each channel floor(255 * level).
// Pipeline: one register per stage from an accepted input beat to its
// output beat (clamp/sector, remainder, saturation multiply,
// brightness multiply, scale and route).
// Throughput: one beat per cycle while i_m_tready is high; every stage
// holds one beat and moves whenever it is empty or the stage after it moves.
// Stall: when i_m_tready is low the output beat holds; upstream stages keep
// accepting until all five are full, then o_s_tready drops. No beat is
// lost or repeated.
// Reset (synchronous, active low) empties the pipeline; there is no other
// state and no configuration.
`default_nettype none

module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [39:0] i_s_tdata,  // hue[14:0], saturation[23:15], brightness[32:24]
    // Output stream
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [23:0] o_m_tdata   // red[7:0], green[15:8], blue[23:16]
);

    logic         w_sec_valid, w_sec_ready;
    t_sector_beat w_sec_beat;
    logic         w_lvl_valid, w_lvl_ready;
    t_level_beat  w_lvl_beat;
    logic [CHAN_W-1:0] w_red, w_green, w_blue;

    // Clamp and sector split
    hsv2rgb_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_hue   (i_s_tdata[HUE_W-1:0]),
        .i_sat   (i_s_tdata[HUE_W +: UNIT_W]),
        .i_bri   (i_s_tdata[HUE_W+UNIT_W +: UNIT_W]),
        .o_valid (w_sec_valid),
        .i_ready (w_sec_ready),
        .o_beat  (w_sec_beat)
    );

    // Inner terms and brightness scaling
    hsv2rgb_level u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sec_valid),
        .o_ready (w_sec_ready),
        .i_beat  (w_sec_beat),
        .o_valid (w_lvl_valid),
        .i_ready (w_lvl_ready),
        .o_beat  (w_lvl_beat)
    );

    // Channel scaling, routing and output register
    hsv2rgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_lvl_valid),
        .o_ready (w_lvl_ready),
        .i_beat  (w_lvl_beat),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    assign o_m_tdata = {w_blue, w_green, w_red};

    // Zero saturation must give grey at the output
    a_grey_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lvl_valid && w_lvl_ready && w_lvl_beat.lvl_p == w_lvl_beat.lvl_v
         && w_lvl_beat.lvl_q == w_lvl_beat.lvl_v && w_lvl_beat.lvl_t == w_lvl_beat.lvl_v)
        |=> (w_red == w_green && w_green == w_blue))
        else $error("equal levels did not give grey");

endmodule

`default_nettype wire
